// ----- sv/ats_pkg.sv -----
package ats_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_BYTE = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	// comment tracking
	typedef enum logic [1:0] {
		CP_NONE = 2'd0,
		CP_OPEN = 2'd1,
		CP_BODY = 2'd2
	} cphase_t;

	localparam int unsigned MaxResults = 4;
	localparam int unsigned IdxW       = $clog2(MaxResults);
	localparam int unsigned CntW       = $clog2(MaxResults + 1);

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] token_byte;
		logic       is_eof_token;
	} res_t;

	typedef struct packed {
		logic [CntW-1:0]             count;
		res_t [MaxResults-1:0]       ent;
	} res_list_t;

	typedef struct packed {
		logic    token_open;
		logic    slash_pending;
		cphase_t comment_phase;
		logic    prev_star;
	} scan_state_t;

	// load request from the scanner to the result buffer
	typedef struct packed {
		logic      load;
		res_list_t lst;
	} load_req_t;

	function automatic logic is_punct(input logic [7:0] c);
		logic r;
		case (c) inside
			8'h21, 8'h22, 8'h23, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
			8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
			8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h5E, 8'h60,
			8'h7B, 8'h7C, 8'h7D, CH_NL: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic res_t mk_res(input kind_t k, input logic [7:0] b, input logic e);
		res_t r;
		r.kind         = k;
		r.token_byte   = b;
		r.is_eof_token = e;
		return r;
	endfunction

endpackage

// ----- sv/ats_in_if.sv -----
interface ats_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       at_end;

	modport source (output valid, output ch, output at_end, input ready);
	modport sink   (input valid, input ch, input at_end, output ready);
endinterface

// ----- sv/ats_out_if.sv -----
interface ats_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] token_byte;
	logic       is_eof_token;
	logic       last;

	modport source (output valid, output kind, output token_byte, output is_eof_token,
		output last, input ready);
	modport sink   (input valid, input kind, input token_byte, input is_eof_token,
		input last, output ready);
endinterface

// ----- sv/ats_decode.sv -----
module ats_decode import ats_pkg::*; (
	input  scan_state_t st,
	input  logic [7:0]  ch,
	input  logic        at_end,
	output res_list_t   lst,
	output scan_state_t nxt
);

	logic [CntW-1:0] n;
	logic            do_plain;

	// one item: build its result list and the next scanner state
	always_comb begin
		lst      = '0;
		n        = '0;
		nxt      = st;
		do_plain = 1'b0;
		if (st.comment_phase != CP_NONE) begin
			if (at_end) begin
				// unterminated comment
				lst.ent[n[IdxW-1:0]] = mk_res(KIND_ERR, 8'h00, 1'b0);
				n = n + 1'b1;
				lst.ent[n[IdxW-1:0]] = mk_res(KIND_BYTE, 8'h00, 1'b1);
				n = n + 1'b1;
				lst.ent[n[IdxW-1:0]] = mk_res(KIND_END, 8'h00, 1'b0);
				n = n + 1'b1;
				nxt.comment_phase = CP_NONE;
				nxt.prev_star     = 1'b0;
			end else if (st.comment_phase == CP_OPEN) begin
				nxt.prev_star     = (ch == CH_STAR);
				nxt.comment_phase = CP_BODY;
			end else if (st.prev_star && ch == CH_SLASH) begin
				nxt.comment_phase = CP_NONE;
				nxt.prev_star     = 1'b0;
			end else begin
				nxt.prev_star = (ch == CH_STAR);
			end
		end else begin
			do_plain = 1'b1;
			if (st.slash_pending) begin
				nxt.slash_pending = 1'b0;
				if (!at_end && ch == CH_STAR) begin
					nxt.comment_phase = CP_OPEN;
					nxt.prev_star     = 1'b0;
					do_plain          = 1'b0;
				end else if (!at_end && ch == CH_SLASH) begin
					// double slash stands for a separator
					lst.ent[n[IdxW-1:0]] = mk_res(KIND_BYTE, CH_SEMI, 1'b0);
					n = n + 1'b1;
					lst.ent[n[IdxW-1:0]] = mk_res(KIND_END, 8'h00, 1'b0);
					n = n + 1'b1;
					do_plain = 1'b0;
				end else begin
					lst.ent[n[IdxW-1:0]] = mk_res(KIND_BYTE, CH_SLASH, 1'b0);
					n = n + 1'b1;
					lst.ent[n[IdxW-1:0]] = mk_res(KIND_END, 8'h00, 1'b0);
					n = n + 1'b1;
				end
			end
			if (do_plain) begin
				if (at_end || is_punct(ch)) begin
					if (st.token_open) begin
						lst.ent[n[IdxW-1:0]] = mk_res(KIND_END, 8'h00, 1'b0);
						n = n + 1'b1;
					end
					nxt.token_open = 1'b0;
					lst.ent[n[IdxW-1:0]] = mk_res(KIND_BYTE, at_end ? 8'h00 : ch, at_end);
					n = n + 1'b1;
					lst.ent[n[IdxW-1:0]] = mk_res(KIND_END, 8'h00, 1'b0);
					n = n + 1'b1;
				end else if (ch == CH_SPACE || ch == CH_TAB || ch == CH_CR ||
						ch == CH_SLASH) begin
					if (st.token_open) begin
						lst.ent[n[IdxW-1:0]] = mk_res(KIND_END, 8'h00, 1'b0);
						n = n + 1'b1;
					end
					nxt.token_open = 1'b0;
					if (ch == CH_SLASH) begin
						nxt.slash_pending = 1'b1;
					end
				end else begin
					lst.ent[n[IdxW-1:0]] = mk_res(KIND_BYTE, ch, 1'b0);
					n = n + 1'b1;
					nxt.token_open = 1'b1;
				end
			end
		end
		lst.count = n;
	end

endmodule

// ----- sv/ats_serializer.sv -----
module ats_serializer import ats_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  load_req_t    req,
	output logic         can_load,
	ats_out_if.source    tokens
);

	logic                  busy_q;
	logic [IdxW-1:0]       idx_q;
	logic [CntW-1:0]       cnt_q;
	res_t [MaxResults-1:0] ent_q;
	logic [CntW-1:0]       cnt_m1;
	logic                  on_last;
	res_t                  cur;

	// current result and last flag
	assign cnt_m1  = cnt_q - 1'b1;
	assign on_last = (idx_q == cnt_m1[IdxW-1:0]);
	assign cur     = ent_q[idx_q];

	assign can_load = !busy_q || (tokens.ready && on_last);

	assign tokens.valid        = busy_q;
	assign tokens.kind         = cur.kind;
	assign tokens.token_byte   = cur.token_byte;
	assign tokens.is_eof_token = cur.is_eof_token;
	assign tokens.last         = on_last;

	// control: busy flag and read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			cnt_q  <= '0;
		end else begin
			if (req.load && can_load && req.lst.count != '0) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				cnt_q  <= req.lst.count;
			end else if (busy_q && tokens.ready) begin
				if (on_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// result entries
	always_ff @(posedge clk) begin
		if (req.load && can_load && req.lst.count != '0) begin
			ent_q <= req.lst.ent;
		end
	end

endmodule

// ----- sv/assembler_token_splitter_unit.sv -----
// channel  | dir | payload                                   | handshake
// src      | in  | ch[7:0], at_end                           | valid/ready
// tokens   | out | kind[1:0], token_byte[7:0], is_eof_token, | valid/ready
//          |     | last                                      |
//
// an item enters the input register, and the results it causes (zero to
// four) are loaded into the result buffer and sent out in order through
// its single read port; an item without results retires at once, and the
// buffer can take new results as its last result is taken.
// reset clears the scanner state and both valid flags.
// a stalled output holds the buffer while the input register keeps one item.
module assembler_token_splitter_unit import ats_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	ats_in_if.sink    src,
	ats_out_if.source tokens
);

	logic        valid_s1;
	logic [7:0]  ch_s1;
	logic        at_end_s1;
	scan_state_t st_q;
	scan_state_t st_nxt;
	res_list_t   lst;
	load_req_t   req;
	logic        can_load;
	logic        move_s1;

	ats_decode u_decode (
		.st     (st_q),
		.ch     (ch_s1),
		.at_end (at_end_s1),
		.lst    (lst),
		.nxt    (st_nxt)
	);

	// hand the item to the buffer, or retire it at once when it has no result
	assign move_s1   = valid_s1 && (lst.count == '0 || can_load);
	assign src.ready = !valid_s1 || move_s1;
	assign req.load  = valid_s1;
	assign req.lst   = lst;

	ats_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.can_load (can_load),
		.tokens   (tokens)
	);

	// input register control and scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1           <= 1'b0;
			st_q.token_open    <= 1'b0;
			st_q.slash_pending <= 1'b0;
			st_q.comment_phase <= CP_NONE;
			st_q.prev_star     <= 1'b0;
		end else begin
			if (src.ready) begin
				valid_s1 <= src.valid;
			end
			if (move_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (src.valid && src.ready) begin
			ch_s1     <= src.ch;
			at_end_s1 <= src.at_end;
		end
	end

endmodule
